FILE: rtl/core/prpi_pkg.sv
// ----------------------------------------------------------------------------
// prpi_pkg
// Shared types, widths, mode codes and datapath operation codes of the
// PageRank power iteration unit.
// ----------------------------------------------------------------------------
package prpi_pkg;

  localparam int MAX_NODES      = 1024;
  localparam int MAX_EDGES      = 4096;
  localparam int RANK_FRAC_BITS = 31;

  localparam int RANK_W     = RANK_FRAC_BITS + 1;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int EDGE_AW    = $clog2(MAX_EDGES);
  localparam int NODE_CNT_W = 11;
  localparam int IN_CNT_W   = 13;
  localparam int OD_W       = 11;
  localparam int ITER_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Accumulators of per-node terms over up to MAX_NODES nodes.
  localparam int DIV_NUM_W = RANK_W + NODE_CNT_W;
  localparam int DIV_DEN_W = OD_W;
  localparam int LEAK_W    = DIV_NUM_W + 1;
  localparam int PROD_W    = 2 * RANK_W;

  localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1) << RANK_FRAC_BITS;

  localparam logic [NODE_CNT_W-1:0] NODE_CNT_MAX = NODE_CNT_W'(MAX_NODES);

  localparam logic [CFG_DATA_W-1:0] DAMPING_RST    = 32'd1825361101;
  localparam logic [CFG_DATA_W-1:0] EPSILON_RST    = 32'd214748;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST   = 16'd1000;
  localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 11'd1;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_WR_NODE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_EDGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RD_RANK = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd3;

  // Result kinds.
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_RANK = 1'b1;

  // Datapath operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE         = 5'd0;
  localparam logic [OP_W-1:0] OP_WR_NODE      = 5'd1;
  localparam logic [OP_W-1:0] OP_WR_EDGE      = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_RANK      = 5'd3;
  localparam logic [OP_W-1:0] OP_RESULT_RANK  = 5'd4;
  localparam logic [OP_W-1:0] OP_RUN_INIT     = 5'd5;
  localparam logic [OP_W-1:0] OP_PASS_INIT    = 5'd6;
  localparam logic [OP_W-1:0] OP_REC_RD       = 5'd7;
  localparam logic [OP_W-1:0] OP_PART_ZERO    = 5'd8;
  localparam logic [OP_W-1:0] OP_EDGE_INIT    = 5'd9;
  localparam logic [OP_W-1:0] OP_EDGE_RD      = 5'd10;
  localparam logic [OP_W-1:0] OP_SRC_RD       = 5'd11;
  localparam logic [OP_W-1:0] OP_CONTRIB_DIV  = 5'd12;
  localparam logic [OP_W-1:0] OP_SUM_ADD      = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL          = 5'd14;
  localparam logic [OP_W-1:0] OP_PART_WR      = 5'd15;
  localparam logic [OP_W-1:0] OP_LEAK_DIV     = 5'd16;
  localparam logic [OP_W-1:0] OP_LEAK_SET     = 5'd17;
  localparam logic [OP_W-1:0] OP_UPD_RD       = 5'd18;
  localparam logic [OP_W-1:0] OP_UPD_WR       = 5'd19;
  localparam logic [OP_W-1:0] OP_ITER_INC     = 5'd20;
  localparam logic [OP_W-1:0] OP_RESULT_RUN   = 5'd21;

  typedef struct packed {
    logic [IN_CNT_W-1:0] in_count;
    logic [EDGE_AW-1:0]  in_start;
    logic [OD_W-1:0]     out_degree;
  } node_rec_t;

  typedef struct packed {
    logic cnt_zero;
    logic od_zero;
    logic k_last;
    logic j_last;
    logic div_done;
    logic dist_lt_eps;
    logic iter_at_cap;
  } prpi_status_t;

endpackage

FILE: rtl/core/prpi_div.sv
// ----------------------------------------------------------------------------
// prpi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prpi_div import prpi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   trial_sub;

  always_comb begin
    trial     = {rem_q, quo_q[DIV_NUM_W-1]};
    trial_sub = trial - {1'b0, den_q};
    quo_d     = quo_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial_sub[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/core/prpi_datapath.sv
// ----------------------------------------------------------------------------
// prpi_datapath
// Graph stores, configuration registers, accumulators and the shared divider.
// ----------------------------------------------------------------------------
module prpi_datapath import prpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [OP_W-1:0]       op_i,
  output prpi_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [NODE_AW-1:0]    node_index_i,
  input  logic [IN_CNT_W-1:0]   in_count_i,
  input  logic [EDGE_AW-1:0]    in_start_i,
  input  logic [OD_W-1:0]       out_degree_i,
  input  logic [RANK_W-1:0]     initial_rank_i,
  input  logic [EDGE_AW-1:0]    edge_index_i,
  input  logic [NODE_AW-1:0]    edge_source_i,
  output logic                  result_valid_o,
  output logic                  result_kind_o,
  output logic [RANK_W-1:0]     rank_o,
  output logic [ITER_W-1:0]     iterations_o,
  output logic                  converged_o
);

  // Configuration.
  logic [NODE_CNT_W-1:0] node_count_q;
  logic [RANK_W-1:0]     damping_q;
  logic [RANK_W-1:0]     epsilon_q;
  logic [ITER_W-1:0]     max_iter_q;

  // Stores.
  node_rec_t          rec_mem     [MAX_NODES];
  logic [RANK_W-1:0]  prev_mem    [MAX_NODES];
  logic [RANK_W-1:0]  part_mem    [MAX_NODES];
  logic [NODE_AW-1:0] edge_mem    [MAX_EDGES];

  node_rec_t          rec_rd_q;
  logic [RANK_W-1:0]  prev_rd_q;
  logic [RANK_W-1:0]  part_rd_q;
  logic [NODE_AW-1:0] edge_rd_q;

  // Working registers.
  logic [NODE_AW-1:0]   j_q;
  logic [IN_CNT_W-1:0]  k_q;
  logic [IN_CNT_W-1:0]  cur_cnt_q;
  logic [EDGE_AW-1:0]   cur_start_q;
  logic [RANK_W-1:0]    sum_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DIV_NUM_W-1:0] leaked_q;
  logic [DIV_NUM_W-1:0] dist_q;
  logic signed [LEAK_W-1:0] leak_q;
  logic                 leak_neg_q;
  logic [ITER_W-1:0]    iter_q;

  logic                 res_valid_q;
  logic                 res_kind_q;
  logic [RANK_W-1:0]    res_rank_q;
  logic [ITER_W-1:0]    res_iter_q;
  logic                 res_conv_q;

  // Derived values.
  logic [NODE_CNT_W-1:0] n_eff;
  logic [ITER_W-1:0]     cap;
  logic [RANK_W-1:0]     damp_sat;
  logic [RANK_W-1:0]     init_sat;
  logic [RANK_W:0]       sum_add;
  logic [RANK_W-1:0]     contrib;
  logic [RANK_W-1:0]     partial;
  logic signed [LEAK_W-1:0] leak_diff;
  logic [LEAK_W-1:0]     leak_mag;
  logic signed [LEAK_W-1:0] cur;
  logic [RANK_W-1:0]     new_rank;
  logic [RANK_W-1:0]     abs_diff;
  logic [NODE_AW-1:0]    rec_addr;
  logic [NODE_AW-1:0]    prev_addr;
  logic [EDGE_AW-1:0]    slot;
  logic [NODE_CNT_W:0]   j_next;
  logic [IN_CNT_W:0]     k_next;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quo;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = NODE_CNT_W'(1);
    end else if (node_count_q > NODE_CNT_MAX) begin
      n_eff = NODE_CNT_MAX;
    end else begin
      n_eff = node_count_q;
    end
    cap      = (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;
    damp_sat = (damping_q > RANK_ONE) ? RANK_ONE : damping_q;
    init_sat = (initial_rank_i > RANK_ONE) ? RANK_ONE : initial_rank_i;

    contrib = rec_rd_q.out_degree == '0 ? '0 : div_quo[RANK_W-1:0];
    sum_add = {1'b0, sum_q} + {1'b0, contrib};
    partial = prod_q[RANK_FRAC_BITS +: RANK_W];

    leak_diff = $signed(LEAK_W'(RANK_ONE)) - $signed({1'b0, leaked_q});
    leak_mag  = leak_diff[LEAK_W-1] ? LEAK_W'(-leak_diff) : LEAK_W'(leak_diff);

    cur = $signed(LEAK_W'(part_rd_q)) + leak_q;
    if (cur[LEAK_W-1]) begin
      new_rank = '0;
    end else if (cur > $signed(LEAK_W'(RANK_ONE))) begin
      new_rank = RANK_ONE;
    end else begin
      new_rank = cur[RANK_W-1:0];
    end
    abs_diff = (new_rank > prev_rd_q) ? new_rank - prev_rd_q : prev_rd_q - new_rank;

    slot   = cur_start_q + k_q[EDGE_AW-1:0];
    j_next = {1'b0, NODE_CNT_W'(j_q)} + (NODE_CNT_W + 1)'(1);
    k_next = {1'b0, k_q} + (IN_CNT_W + 1)'(1);

    rec_addr  = (op_i == OP_SRC_RD) ? edge_rd_q : j_q;
    case (op_i)
      OP_RD_RANK: prev_addr = node_index_i;
      OP_SRC_RD:  prev_addr = edge_rd_q;
      default:    prev_addr = j_q;
    endcase

    div_start = (op_i == OP_CONTRIB_DIV) || (op_i == OP_LEAK_DIV);
    if (op_i == OP_LEAK_DIV) begin
      div_num = leak_mag[DIV_NUM_W-1:0];
      div_den = n_eff;
    end else begin
      div_num = DIV_NUM_W'(prev_rd_q);
      div_den = rec_rd_q.out_degree;
    end
  end

  prpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Memories. The record register keeps the source record until the
  // contribution is summed.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_WR_NODE) begin
      rec_mem[node_index_i] <= '{in_count: in_count_i, in_start: in_start_i,
                                 out_degree: out_degree_i};
    end
    if ((op_i == OP_REC_RD) || (op_i == OP_SRC_RD)) begin
      rec_rd_q <= rec_mem[rec_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_WR_NODE) begin
      prev_mem[node_index_i] <= init_sat;
    end else if (op_i == OP_UPD_WR) begin
      prev_mem[j_q] <= new_rank;
    end
    prev_rd_q <= prev_mem[prev_addr];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PART_WR) begin
      part_mem[j_q] <= partial;
    end else if (op_i == OP_PART_ZERO) begin
      part_mem[j_q] <= '0;
    end
    part_rd_q <= part_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_WR_EDGE) begin
      edge_mem[edge_index_i] <= edge_source_i;
    end
    edge_rd_q <= edge_mem[slot];
  end

  // Configuration and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      damping_q    <= DAMPING_RST;
      epsilon_q    <= EPSILON_RST;
      max_iter_q   <= MAX_ITER_RST;
      iter_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[NODE_CNT_W-1:0];
          CFG_DAMPING:    damping_q    <= cfg_data_i[RANK_W-1:0];
          CFG_EPSILON:    epsilon_q    <= cfg_data_i[RANK_W-1:0];
          CFG_MAX_ITER:   max_iter_q   <= cfg_data_i[ITER_W-1:0];
          default:        ;
        endcase
      end
      if (op_i == OP_RUN_INIT) begin
        iter_q <= '0;
      end else if (op_i == OP_ITER_INC) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      res_valid_q <= (op_i == OP_RESULT_RUN) || (op_i == OP_RESULT_RANK);
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_RUN_INIT, OP_PASS_INIT: begin
        j_q      <= '0;
        leaked_q <= '0;
        dist_q   <= '0;
      end
      OP_PART_ZERO: begin
        j_q <= j_q + NODE_AW'(1);
      end
      OP_EDGE_INIT: begin
        k_q         <= '0;
        sum_q       <= '0;
        cur_cnt_q   <= rec_rd_q.in_count;
        cur_start_q <= rec_rd_q.in_start;
      end
      OP_SUM_ADD: begin
        sum_q <= (sum_add > {1'b0, RANK_ONE}) ? RANK_ONE : sum_add[RANK_W-1:0];
        k_q   <= k_q + IN_CNT_W'(1);
      end
      OP_MUL: begin
        prod_q <= damp_sat * sum_q;
      end
      OP_PART_WR: begin
        leaked_q <= leaked_q + DIV_NUM_W'(partial);
        j_q      <= j_q + NODE_AW'(1);
      end
      OP_LEAK_DIV: begin
        leak_neg_q <= leak_diff[LEAK_W-1];
      end
      OP_LEAK_SET: begin
        leak_q <= leak_neg_q ? -$signed(LEAK_W'(div_quo)) : $signed(LEAK_W'(div_quo));
        j_q    <= '0;
      end
      OP_UPD_WR: begin
        dist_q <= dist_q + DIV_NUM_W'(abs_diff);
        j_q    <= j_q + NODE_AW'(1);
      end
      OP_RESULT_RUN: begin
        res_kind_q <= KIND_RUN;
        res_rank_q <= '0;
        res_iter_q <= iter_q;
        res_conv_q <= (dist_q < DIV_NUM_W'(epsilon_q));
      end
      OP_RESULT_RANK: begin
        res_kind_q <= KIND_RANK;
        res_rank_q <= prev_rd_q;
        res_iter_q <= '0;
        res_conv_q <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.cnt_zero    = (rec_rd_q.in_count == '0);
    status_o.od_zero     = (rec_rd_q.out_degree == '0);
    status_o.k_last      = (k_next == {1'b0, cur_cnt_q});
    status_o.j_last      = (j_next == {1'b0, n_eff});
    status_o.div_done    = div_done;
    status_o.dist_lt_eps = (dist_q < DIV_NUM_W'(epsilon_q));
    status_o.iter_at_cap = (iter_q >= cap);
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign rank_o         = res_rank_q;
  assign iterations_o   = res_iter_q;
  assign converged_o    = res_conv_q;

endmodule

FILE: rtl/core/prpi_ctrl.sv
// ----------------------------------------------------------------------------
// prpi_ctrl
// Sequencer that walks loads, rank reads and power iteration passes.
// ----------------------------------------------------------------------------
module prpi_ctrl import prpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  prpi_status_t      status_i,
  output logic [OP_W-1:0]   op_o,
  output logic              busy_o
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE      = 5'd0;
  localparam logic [ST_W-1:0] S_RD_OUT    = 5'd1;
  localparam logic [ST_W-1:0] S_REC_RD    = 5'd2;
  localparam logic [ST_W-1:0] S_REC_CHK   = 5'd3;
  localparam logic [ST_W-1:0] S_EDGE_RD   = 5'd4;
  localparam logic [ST_W-1:0] S_SRC_RD    = 5'd5;
  localparam logic [ST_W-1:0] S_SRC_CHK   = 5'd6;
  localparam logic [ST_W-1:0] S_DIV_WAIT  = 5'd7;
  localparam logic [ST_W-1:0] S_SUM_ADD   = 5'd8;
  localparam logic [ST_W-1:0] S_MUL       = 5'd9;
  localparam logic [ST_W-1:0] S_PART      = 5'd10;
  localparam logic [ST_W-1:0] S_LEAK_DIV  = 5'd11;
  localparam logic [ST_W-1:0] S_LEAK_WAIT = 5'd12;
  localparam logic [ST_W-1:0] S_LEAK_SET  = 5'd13;
  localparam logic [ST_W-1:0] S_UPD_RD    = 5'd14;
  localparam logic [ST_W-1:0] S_UPD_WR    = 5'd15;
  localparam logic [ST_W-1:0] S_ITER      = 5'd16;
  localparam logic [ST_W-1:0] S_CHECK     = 5'd17;
  localparam logic [ST_W-1:0] S_FINISH    = 5'd18;

  logic [ST_W-1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (mode_i)
            MODE_WR_NODE: op_o = OP_WR_NODE;
            MODE_WR_EDGE: op_o = OP_WR_EDGE;
            MODE_RUN: begin
              op_o    = OP_RUN_INIT;
              state_d = S_REC_RD;
            end
            default: begin
              op_o    = OP_RD_RANK;
              state_d = S_RD_OUT;
            end
          endcase
        end
      end
      S_RD_OUT: begin
        op_o    = OP_RESULT_RANK;
        state_d = S_IDLE;
      end
      S_REC_RD: begin
        op_o    = OP_REC_RD;
        state_d = S_REC_CHK;
      end
      S_REC_CHK: begin
        if (status_i.cnt_zero) begin
          op_o    = OP_PART_ZERO;
          state_d = status_i.j_last ? S_LEAK_DIV : S_REC_RD;
        end else begin
          op_o    = OP_EDGE_INIT;
          state_d = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        op_o    = OP_EDGE_RD;
        state_d = S_SRC_RD;
      end
      S_SRC_RD: begin
        op_o    = OP_SRC_RD;
        state_d = S_SRC_CHK;
      end
      S_SRC_CHK: begin
        if (status_i.od_zero) begin
          state_d = S_SUM_ADD;
        end else begin
          op_o    = OP_CONTRIB_DIV;
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_SUM_ADD;
        end
      end
      S_SUM_ADD: begin
        op_o    = OP_SUM_ADD;
        state_d = status_i.k_last ? S_MUL : S_EDGE_RD;
      end
      S_MUL: begin
        op_o    = OP_MUL;
        state_d = S_PART;
      end
      S_PART: begin
        op_o    = OP_PART_WR;
        state_d = status_i.j_last ? S_LEAK_DIV : S_REC_RD;
      end
      S_LEAK_DIV: begin
        op_o    = OP_LEAK_DIV;
        state_d = S_LEAK_WAIT;
      end
      S_LEAK_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_LEAK_SET;
        end
      end
      S_LEAK_SET: begin
        op_o    = OP_LEAK_SET;
        state_d = S_UPD_RD;
      end
      S_UPD_RD: begin
        op_o    = OP_UPD_RD;
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        op_o    = OP_UPD_WR;
        state_d = status_i.j_last ? S_ITER : S_UPD_RD;
      end
      S_ITER: begin
        op_o    = OP_ITER_INC;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.dist_lt_eps || status_i.iter_at_cap) begin
          state_d = S_FINISH;
        end else begin
          op_o    = OP_PASS_INIT;
          state_d = S_REC_RD;
        end
      end
      S_FINISH: begin
        op_o    = OP_RESULT_RUN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/pagerank_power_iteration_unit.sv
// ----------------------------------------------------------------------------
// pagerank_power_iteration_unit
// PageRank power iteration over a graph held in on-chip memories.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Node and edge
// write items leave busy_o low, so a load streams at one item per cycle.
// A rank read item holds busy_o for one cycle and its result strobes on
// result_valid_o in the cycle after that. A run item holds busy_o until the
// cycle in which its result strobes. In each pass the bit-serial divider
// forms a neighbour's share (rank / out-degree) or the leaked-rank share;
// an edge from a node of zero out-degree skips the divider. Each memory has
// a single read port. Results cannot be held off: result_valid_o is high
// for exactly one cycle and every other result port is valid in that cycle.
// Configuration writes are always accepted (cfg_ready_o is high) and must only
// be issued while the unit is idle. The stores have no reset; reading a node
// or edge that was never written gives undefined data.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_unit import prpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item channel.
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [NODE_AW-1:0]    node_index_i,
  input  logic [IN_CNT_W-1:0]   in_count_i,
  input  logic [EDGE_AW-1:0]    in_start_i,
  input  logic [OD_W-1:0]       out_degree_i,
  input  logic [RANK_W-1:0]     initial_rank_i,
  input  logic [EDGE_AW-1:0]    edge_index_i,
  input  logic [NODE_AW-1:0]    edge_source_i,
  // Result channel.
  output logic                  result_valid_o,
  output logic                  result_kind_o,
  output logic [RANK_W-1:0]     rank_o,
  output logic [ITER_W-1:0]     iterations_o,
  output logic                  converged_o,
  // Configuration channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [OP_W-1:0] op;
  prpi_status_t    status;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  // The controller sequences every item; the datapath only follows its ops.
  prpi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_o)
  );

  prpi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .node_index_i   (node_index_i),
    .in_count_i     (in_count_i),
    .in_start_i     (in_start_i),
    .out_degree_i   (out_degree_i),
    .initial_rank_i (initial_rank_i),
    .edge_index_i   (edge_index_i),
    .edge_source_i  (edge_source_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .rank_o         (rank_o),
    .iterations_o   (iterations_o),
    .converged_o    (converged_o)
  );

endmodule

FILE: rtl/core/prpi_checker.sv
// ----------------------------------------------------------------------------
// prpi_checker
// Port-level checks of the PageRank power iteration unit.
// ----------------------------------------------------------------------------
module prpi_checker import prpi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [MODE_W-1:0] mode_i,
  input logic              result_valid_o,
  input logic              result_kind_o,
  input logic [RANK_W-1:0] rank_o,
  input logic [ITER_W-1:0] iterations_o,
  input logic              converged_o
);

  // Results come one at a time, never back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  // A run keeps the unit busy in the cycle after it is taken.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_RUN) |=> busy_o)
    else $error("run item did not raise busy");

  // Loads give no result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == MODE_WR_NODE || mode_i == MODE_WR_EDGE))
      |=> !result_valid_o)
    else $error("load item produced a result");

  // A finished run has performed at least one pass and reports no rank.
  a_run_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == KIND_RUN) |-> (iterations_o != '0 && rank_o == '0))
    else $error("malformed run result");

  // A rank read stays within 1.0 and carries no run status.
  a_rank_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == KIND_RANK)
      |-> (rank_o <= RANK_ONE && iterations_o == '0 && !converged_o))
    else $error("malformed rank result");

endmodule

bind pagerank_power_iteration_unit prpi_checker u_prpi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .rank_o         (rank_o),
  .iterations_o   (iterations_o),
  .converged_o    (converged_o)
);
